@@ hw/rtl/bse_pkg.sv @@
package bse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int LOCAL_SLOTS = 8;

    localparam int DATA_W   = 64;
    localparam int OP_W     = 8;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 3;
    localparam int SP_W     = $clog2(STACK_DEPTH + 1);
    localparam int LOC_W    = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

    localparam int S_FIELDS_W = OP_W + SLOT_W + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = DATA_W;

    localparam logic [OP_W-1:0] OP_ILOAD_0 = 8'h1a;
    localparam logic [OP_W-1:0] OP_ILOAD_2 = 8'h1c;
    localparam logic [OP_W-1:0] OP_LLOAD_0 = 8'h1e;
    localparam logic [OP_W-1:0] OP_LLOAD_2 = 8'h20;
    localparam logic [OP_W-1:0] OP_IADD    = 8'h60;
    localparam logic [OP_W-1:0] OP_LADD    = 8'h61;
    localparam logic [OP_W-1:0] OP_I2L     = 8'h85;
    localparam logic [OP_W-1:0] OP_IRETURN = 8'hac;
    localparam logic [OP_W-1:0] OP_LRETURN = 8'had;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXEC     = 3'd0,
        ST_RET_INT  = 3'd1,
        ST_RET_LONG = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_FAULT    = 3'd4
    } status_t;

    function automatic logic [DATA_W-1:0] sext32(input logic [DATA_W-1:0] v);
        return {{(DATA_W - 32){v[31]}}, v[31:0]};
    endfunction

endpackage

@@ hw/rtl/bytecode_stack_executor_unit.sv @@
// Executes a small set of JVM bytecodes on a stack of 64-bit entries and a set of locals.
// Input channel (s_): one beat is either an argument write (s_tuser = 1), which stores
// arg_value into local slot arg_slot, or an opcode to execute (s_tuser = 0).
// Result channel (m_): exactly one beat per input beat, in order; m_tuser carries the
// status (executed, returned int, returned long, unknown opcode, stack fault) and
// m_tdata the returned value, which is zero unless the status is a return.
// The result beat is registered and appears in the cycle after its input is accepted,
// and a new beat may be accepted in every cycle while the receiver takes results: the
// whole of one bytecode is evaluated between the input port and the result register,
// with the top two stack entries read at fixed places of a shifting register stack.
// If the receiver stalls, the pending result is held in the result register and
// s_tready stays low until it is taken; the input is accepted in the same cycle as
// the result leaves.
// Reset empties the stack and clears the result channel; locals and stack contents
// are left undefined until written.
module bytecode_stack_executor_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // opcode [7:0], arg_slot [10:8], arg_value [74:11], zero [79:75]
    input  logic [bse_pkg::S_TDATA_W-1:0]    s_tdata,
    // load_arg [0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_value [63:0]
    output logic [bse_pkg::M_TDATA_W-1:0]    m_tdata,
    // status [2:0]
    output logic [bse_pkg::STATUS_W-1:0]     m_tuser
);

    localparam logic [bse_pkg::SP_W-1:0] SP_FULL = bse_pkg::SP_W'(bse_pkg::STACK_DEPTH);
    localparam logic [bse_pkg::SP_W-1:0] SP_ONE  = bse_pkg::SP_W'(1);
    localparam logic [bse_pkg::SP_W-1:0] SP_TWO  = bse_pkg::SP_W'(2);

    logic [bse_pkg::DATA_W-1:0] stk_reg [bse_pkg::STACK_DEPTH];
    logic [bse_pkg::DATA_W-1:0] loc_reg [bse_pkg::LOCAL_SLOTS];
    logic [bse_pkg::SP_W-1:0]   sp_reg, sp_next;

    logic                       m_valid_reg;
    bse_pkg::status_t           m_status_reg, m_status_next;
    logic [bse_pkg::DATA_W-1:0] m_value_reg, m_value_next;

    logic                        accept;
    logic [bse_pkg::OP_W-1:0]    opcode;
    logic [bse_pkg::SLOT_W-1:0]  arg_slot;
    logic [bse_pkg::DATA_W-1:0]  arg_value;
    logic [1:0]                  load_idx;
    logic [bse_pkg::DATA_W-1:0]  load_val;
    logic [bse_pkg::DATA_W-1:0]  top_new;
    logic                        do_push, do_pop, do_top;

    assign opcode    = s_tdata[bse_pkg::OP_W-1:0];
    assign arg_slot  = s_tdata[bse_pkg::OP_W +: bse_pkg::SLOT_W];
    assign arg_value = s_tdata[bse_pkg::OP_W + bse_pkg::SLOT_W +: bse_pkg::DATA_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        case (load_idx)
            2'd0:    load_val = loc_reg[0];
            2'd1:    load_val = loc_reg[1];
            default: load_val = loc_reg[2];
        endcase
    end

    always_comb begin
        m_status_next = bse_pkg::ST_EXEC;
        m_value_next  = '0;
        sp_next       = sp_reg;
        load_idx      = 2'd0;
        top_new       = load_val;
        do_push       = 1'b0;
        do_pop        = 1'b0;
        do_top        = 1'b0;
        if (!s_tuser) begin
            unique case (opcode) inside
                [bse_pkg::OP_ILOAD_0:bse_pkg::OP_ILOAD_2],
                [bse_pkg::OP_LLOAD_0:bse_pkg::OP_LLOAD_2]: begin
                    if (opcode <= bse_pkg::OP_ILOAD_2) begin
                        load_idx = 2'(opcode - bse_pkg::OP_ILOAD_0);
                    end else begin
                        load_idx = 2'(opcode - bse_pkg::OP_LLOAD_0);
                    end
                    if (sp_reg == SP_FULL) begin
                        m_status_next = bse_pkg::ST_FAULT;
                    end else begin
                        top_new = load_val;
                        do_push = 1'b1;
                        sp_next = sp_reg + SP_ONE;
                    end
                end
                bse_pkg::OP_IADD, bse_pkg::OP_LADD: begin
                    if (sp_reg < SP_TWO) begin
                        m_status_next = bse_pkg::ST_FAULT;
                    end else begin
                        if (opcode == bse_pkg::OP_IADD) begin
                            top_new = {stk_reg[1][bse_pkg::DATA_W-1:32],
                                       stk_reg[0][31:0] + stk_reg[1][31:0]};
                        end else begin
                            top_new = stk_reg[0] + stk_reg[1];
                        end
                        do_pop  = 1'b1;
                        sp_next = sp_reg - SP_ONE;
                    end
                end
                bse_pkg::OP_I2L: begin
                    if (sp_reg < SP_ONE) begin
                        m_status_next = bse_pkg::ST_FAULT;
                    end else begin
                        top_new = bse_pkg::sext32(stk_reg[0]);
                        do_top  = 1'b1;
                    end
                end
                bse_pkg::OP_IRETURN, bse_pkg::OP_LRETURN: begin
                    if (sp_reg < SP_ONE) begin
                        m_status_next = bse_pkg::ST_FAULT;
                    end else if (opcode == bse_pkg::OP_IRETURN) begin
                        m_status_next = bse_pkg::ST_RET_INT;
                        m_value_next  = bse_pkg::sext32(stk_reg[0]);
                        sp_next       = '0;
                    end else begin
                        m_status_next = bse_pkg::ST_RET_LONG;
                        m_value_next  = stk_reg[0];
                        sp_next       = '0;
                    end
                end
                default: begin
                    m_status_next = bse_pkg::ST_UNKNOWN;
                end
            endcase
        end
    end

    // Entry 0 of the stack register is always the top of stack.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (do_push) begin
                stk_reg[0] <= top_new;
                for (int i = 1; i < bse_pkg::STACK_DEPTH; i++) begin
                    stk_reg[i] <= stk_reg[i-1];
                end
            end else if (do_pop) begin
                stk_reg[0] <= top_new;
                for (int i = 1; i < bse_pkg::STACK_DEPTH - 1; i++) begin
                    stk_reg[i] <= stk_reg[i+1];
                end
            end else if (do_top) begin
                stk_reg[0] <= top_new;
            end
            if (s_tuser && (int'(arg_slot) < bse_pkg::LOCAL_SLOTS)) begin
                loc_reg[bse_pkg::LOC_W'(arg_slot)] <= arg_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                sp_reg <= sp_next;
            end
            if (s_tready) begin
                m_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg <= m_status_next;
            m_value_reg  <= m_value_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

    a_sp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond stack depth");

    a_return_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (m_status_next == bse_pkg::ST_RET_INT ||
                   m_status_next == bse_pkg::ST_RET_LONG) |=> sp_reg == '0)
        else $error("stack not emptied after a return");

    a_fault_keeps_sp: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (m_status_next == bse_pkg::ST_FAULT ||
                   m_status_next == bse_pkg::ST_UNKNOWN) |=> sp_reg == $past(sp_reg))
        else $error("stack pointer changed on a fault or unknown opcode");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != bse_pkg::ST_RET_INT && m_tuser != bse_pkg::ST_RET_LONG
        |-> m_tdata == '0)
        else $error("non-zero value on a result that is not a return");

endmodule
